// File: hdl/assert_macros.svh
// Assertion macros shared by the run former RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/rsrf_pkg.sv
// Types and constants shared by the replacement selection run former.
`timescale 1ns / 1ps

package rsrf_pkg;

	localparam int KEY_W = 32;
	localparam int CFG_W = 6;

	// Most negative key; the run boundary restarts from here.
	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

	// Sequencer states of the selection engine.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_HEAD_LD,
		ST_EMIT,
		ST_REM_SHIFT,
		ST_INS_CHK,
		ST_INS_CMP
	} state_t;

	// Result request from the engine to the output register.
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] value;
		logic             nr;
		logic             eos;
		logic             last;
	} emit_t;

endpackage

// File: hdl/rsrf_cmp.sv
// Shared signed key comparator used by the scan and insert compare steps of the sequencer.
`timescale 1ns / 1ps

module rsrf_cmp
	import rsrf_pkg::*;
(
	input  logic signed [KEY_W-1:0] a,
	input  logic signed [KEY_W-1:0] b,
	output logic                    lt
);

	// Single signed less-than; operands are steered by the sequencer.
	assign lt = (a < b);

endmodule

// File: hdl/rsrf_ctrl.sv
// Selection engine: sorted key memory, sequencer and run state.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsrf_ctrl
	import rsrf_pkg::*;
#(
	parameter int CAPACITY = 32
)
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [CFG_W-1:0]        cap,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [KEY_W-1:0] in_value,
	input  logic                    in_last,
	output emit_t                   emit,
	input  logic                    emit_ready
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t                  state_q, state_d;
	logic [CW-1:0]           idx_q, idx_d;
	logic [CW-1:0]           j_q, j_d;
	logic [CW-1:0]           ec_q, ec_d;
	logic signed [KEY_W-1:0] last_q, last_d;
	logic                    run_open_q, run_d;
	logic                    drain_q, drain_d;
	logic signed [KEY_W-1:0] sel_q, sel_d;
	logic                    nr_q, nr_d;
	logic signed [KEY_W-1:0] key_q;
	logic                    eoi_q;

	logic [KEY_W-1:0]        mem [CAPACITY];
	logic signed [KEY_W-1:0] rd_data;
	logic [IW-1:0]           rd_addr;
	logic                    wr_en;
	logic [IW-1:0]           wr_addr;
	logic signed [KEY_W-1:0] wr_data;

	logic signed [KEY_W-1:0] cmp_a, cmp_b;
	logic                    cmp_lt;

	logic [CW-1:0] eff;
	logic [CW:0]   idx_p1, idx_p2;
	logic [CW-1:0] j_m1, j_m2, ec_dec;
	logic          ec_one, take, finish_rem, finish_ins;

	// Effective capacity: zero counts as one, large values clip to the memory size.
	always_comb begin
		if (cap == '0) begin
			eff = CW'(1);
		end else if (cap > CFG_W'(CAPACITY)) begin
			eff = CW'(CAPACITY);
		end else begin
			eff = cap[CW-1:0];
		end
	end

	assign idx_p1 = {1'b0, idx_q} + 1'b1;
	assign idx_p2 = {1'b0, idx_q} + 2'd2;
	assign j_m1   = j_q - 1'b1;
	assign j_m2   = j_q - 2'd2;
	assign ec_dec = ec_q - 1'b1;
	assign ec_one = (ec_q == CW'(1));
	assign take   = in_valid && in_ready;

	// The one comparator of the engine.
	rsrf_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.lt (cmp_lt)
	);

	// Sorted key memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

	// Sequencer next state and per-state datapath control.
	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		j_d        = j_q;
		ec_d       = ec_q;
		last_d     = last_q;
		run_d      = run_open_q;
		drain_d    = drain_q;
		sel_d      = sel_q;
		nr_d       = nr_q;
		rd_addr    = idx_q[IW-1:0];
		wr_en      = 1'b0;
		wr_addr    = j_q[IW-1:0];
		wr_data    = rd_data;
		cmp_a      = rd_data;
		cmp_b      = last_q;
		in_ready   = 1'b0;
		finish_rem = 1'b0;
		finish_ins = 1'b0;
		emit.valid = 1'b0;
		emit.value = sel_q;
		emit.nr    = nr_q;
		emit.eos   = drain_q && ec_one;
		emit.last  = drain_q ? ec_one : !eoi_q;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					drain_d = 1'b0;
					if (ec_q < eff) begin
						j_d     = ec_q;
						state_d = ST_INS_CHK;
					end else begin
						idx_d   = '0;
						state_d = ST_SCAN_RD;
					end
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				// Walk up the sorted keys until one is not below the last output; if none is, start a new run from the head.
				rd_addr = idx_p1[IW-1:0];
				if (cmp_lt) begin
					if (idx_p1 < {1'b0, ec_q}) begin
						idx_d = idx_p1[CW-1:0];
					end else begin
						rd_addr = '0;
						idx_d   = '0;
						nr_d    = 1'b1;
						state_d = ST_HEAD_LD;
					end
				end else begin
					sel_d   = rd_data;
					nr_d    = !run_open_q;
					state_d = ST_EMIT;
				end
			end
			ST_HEAD_LD: begin
				sel_d   = rd_data;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				emit.valid = 1'b1;
				if (emit_ready) begin
					last_d = sel_q;
					run_d  = 1'b1;
					if (idx_p1 < {1'b0, ec_q}) begin
						rd_addr = idx_p1[IW-1:0];
						state_d = ST_REM_SHIFT;
					end else begin
						finish_rem = 1'b1;
					end
				end
			end
			ST_REM_SHIFT: begin
				// Close the gap left by the emitted key, one entry a cycle.
				wr_en   = 1'b1;
				wr_addr = idx_q[IW-1:0];
				wr_data = rd_data;
				rd_addr = idx_p2[IW-1:0];
				idx_d   = idx_p1[CW-1:0];
				if (!(idx_p2 < {1'b0, ec_q})) begin
					finish_rem = 1'b1;
				end
			end
			ST_INS_CHK: begin
				if (j_q == '0) begin
					wr_en      = 1'b1;
					wr_addr    = '0;
					wr_data    = key_q;
					finish_ins = 1'b1;
				end else begin
					rd_addr = j_m1[IW-1:0];
					state_d = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				// Move larger keys up one place until the new key fits.
				cmp_a  = key_q;
				cmp_b  = rd_data;
				wr_en  = 1'b1;
				if (cmp_lt) begin
					wr_data = rd_data;
					rd_addr = j_m2[IW-1:0];
					j_d     = j_m1;
					if (j_q == CW'(1)) begin
						state_d = ST_INS_CHK;
					end
				end else begin
					wr_data    = key_q;
					finish_ins = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// After a removal: keep draining, close the stream, or insert the new key.
		if (finish_rem) begin
			ec_d = ec_dec;
			if (drain_q) begin
				if (ec_dec != '0) begin
					idx_d   = '0;
					state_d = ST_SCAN_RD;
				end else begin
					last_d  = KEY_MIN;
					run_d   = 1'b0;
					drain_d = 1'b0;
					state_d = ST_IDLE;
				end
			end else begin
				j_d     = ec_dec;
				state_d = ST_INS_CHK;
			end
		end

		// After an insertion: start the drain on the final item, else return to idle.
		if (finish_ins) begin
			ec_d = ec_q + 1'b1;
			if (eoi_q) begin
				drain_d = 1'b1;
				idx_d   = '0;
				state_d = ST_SCAN_RD;
			end else begin
				state_d = ST_IDLE;
			end
		end
	end

	// Control and run state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			j_q        <= '0;
			ec_q       <= '0;
			last_q     <= KEY_MIN;
			run_open_q <= 1'b0;
			drain_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			j_q        <= j_d;
			ec_q       <= ec_d;
			last_q     <= last_d;
			run_open_q <= run_d;
			drain_q    <= drain_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		sel_q <= sel_d;
		nr_q  <= nr_d;
		if (take) begin
			key_q <= in_value;
			eoi_q <= in_last;
		end
	end

	`ASSERT_ALWAYS(a_count_bound, ec_q <= CW'(CAPACITY), "entry count beyond memory size")
	`ASSERT_ALWAYS(a_empty_reset, !(state_q == ST_IDLE && ec_q == '0) || (!run_open_q && last_q == KEY_MIN), "empty buffer with stale run state")
	`ASSERT_NEXT(a_drain_end, state_q == ST_EMIT && emit_ready && drain_q && ec_one, state_q == ST_IDLE && ec_q == '0 && !run_open_q, "drain did not return to idle")

endmodule

// File: hdl/replacement_selection_run_former.sv
// Top level of the replacement selection run former.
// Keys arrive on the s_axis stream, one signed 32-bit key per request in
// s_axis_tdata; s_axis_tlast marks the final key, after which the whole
// buffer is drained. Keys leave on the m_axis stream: m_axis_tdata holds the
// key, m_axis_tuser flags the first key of a run and the last result of an
// input request, and m_axis_tlast marks the very last key of a drain.
// The cfg channel writes the number of buffer entries in use (reset 32,
// zero counts as one, values above CAPACITY clip); write it only when idle.
// One request is handled at a time and s_axis_tready is low meanwhile. A key
// that only fills the buffer is inserted by moving each larger key up one
// place. With a full buffer a key passes through a scan, the gap removal
// and the ordered insert, each stepping through the entries one at a time,
// all through the one read port of the key memory. Its result is offered
// once the scan finds it, before the removal and the insert. Each drained
// key adds a scan and a gap removal.
// Reset empties the buffer and closes any open run. A result waits in the
// output register while m_axis_tready is low, and the engine stalls behind
// it until that result is taken.
`timescale 1ns / 1ps

module replacement_selection_run_former
	import rsrf_pkg::*;
#(
	parameter int CAPACITY = 32
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [KEY_W-1:0] s_axis_tdata,  // [31:0] value
	input  logic             s_axis_tlast,  // end_of_input
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [KEY_W-1:0] m_axis_tdata,  // [31:0] out_value
	output logic             m_axis_tlast,  // end_of_stream
	output logic [1:0]       m_axis_tuser,  // [0] starts_new_run, [1] last_of_item
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] cap_q;
	emit_t            emit;
	logic             emit_ready;
	logic             out_valid_q;
	logic [KEY_W-1:0] out_value_q;
	logic             out_nr_q, out_eos_q, out_last_q;

	// Capacity register; always ready for a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CFG_W'(32);
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	rsrf_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cap        (cap_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_value   (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.emit       (emit),
		.emit_ready (emit_ready)
	);

	// Output register: a new result loads when empty or being taken.
	assign emit_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid && emit_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid && emit_ready) begin
			out_value_q <= emit.value;
			out_nr_q    <= emit.nr;
			out_eos_q   <= emit.eos;
			out_last_q  <= emit.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tlast  = out_eos_q;
	assign m_axis_tuser  = {out_last_q, out_nr_q};

endmodule
